@@ src/hatgz_pkg.sv @@
package hatgz_pkg;

  // Operation codes of an input item
  typedef enum logic [2:0] {
    OP_UPDATE    = 3'd0,
    OP_SET_ZERO  = 3'd1,
    OP_SAVE      = 3'd2,
    OP_GOTO_ZERO = 3'd3,
    OP_CAL_ZERO  = 3'd4,
    OP_RESYNC    = 3'd5
  } op_t;

  // Motor commands of a result item
  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_STOP    = 2'd1,
    CMD_RUN_REV = 2'd2,
    CMD_RUN_FWD = 2'd3
  } motor_cmd_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_PAIR_COUNT     = 2'd0,
    CFG_RATIO_X10      = 2'd1,
    CFG_ZERO_THRESHOLD = 2'd2
  } cfg_index_t;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PP_W    = 8;
  localparam int unsigned RATIO_W = 16;
  localparam int unsigned THR_W   = 11;

  localparam int unsigned SCALE_W = 14;
  localparam int unsigned PROD_W  = DATA_W + SCALE_W;    // dividend width
  localparam int unsigned DIVR_W  = PP_W + RATIO_W;      // divisor width
  localparam int unsigned SUM_W   = PROD_W + 2;
  localparam int unsigned CNT_W   = $clog2(PROD_W);

  localparam logic [SCALE_W-1:0] PULSE_SCALE = 14'd9000;
  localparam logic [THR_W-1:0]   THRESH_MIN  = 11'd1;
  localparam logic [THR_W-1:0]   THRESH_MAX  = 11'd1800;

  localparam logic [PP_W-1:0]    PAIR_COUNT_RST = 8'd3;
  localparam logic [RATIO_W-1:0] RATIO_X10_RST  = 16'd10;
  localparam logic [THR_W-1:0]   THRESHOLD_RST  = 11'd50;

endpackage

@@ src/hatgz_in_if.sv @@
interface hatgz_in_if import hatgz_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [DATA_W-1:0] accum;

  modport source (output valid, output op, output accum, input ready);
  modport sink (input valid, input op, input accum, output ready);
endinterface

@@ src/hatgz_out_if.sv @@
interface hatgz_out_if import hatgz_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] offset;
  logic signed [DATA_W-1:0] stored_offset;
  logic [CMD_W-1:0]         motor_cmd;
  logic                     goto_busy;

  modport source (output valid, output offset, output stored_offset, output motor_cmd,
                  output goto_busy, input ready);
  modport sink (input valid, input offset, input stored_offset, input motor_cmd,
                input goto_busy, output ready);
endinterface

@@ src/hall_angle_tracker_goto_zero_top.sv @@
// Channel   Dir  Handshake               Item
// in_ch     in   valid/ready             op[2:0], accum[31:0] signed
// out_ch    out  valid/ready             offset, stored_offset, motor_cmd[1:0], goto_busy
// cfg       in   cfg_we (no wait)        cfg_index[1:0], cfg_data[15:0]
//
// One item at a time. An update with a nonzero pulse delta and nonzero gearing steps
// through S_PREP, S_MUL, the bit-serial restoring divider in S_DIV (one quotient bit
// per cycle over the 46-bit scaled delta), S_APPLY, S_FIN and S_OUT; an update that
// skips the divide goes from S_MUL to S_FIN, and any other item from S_PREP to S_FIN.
// in_ch.ready is high only while the sequencer is idle; a result waits in the output
// register, and the next item may be accepted while it does.
// rst is synchronous, active high; it restores the register defaults and clears state.
module hall_angle_tracker_goto_zero_top import hatgz_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  hatgz_in_if.sink             in_ch,
  hatgz_out_if.source          out_ch
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PREP  = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_APPLY = 7'b0010000,
    S_FIN   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;

  // configuration
  logic [PP_W-1:0]    pair_count;
  logic [RATIO_W-1:0] ratio_x10;
  logic [THR_W-1:0]   zero_threshold;

  // tracker state
  logic signed [DATA_W-1:0] live_offset;
  logic [DATA_W-1:0]        last_sample;
  logic signed [DATA_W-1:0] saved_offset;
  logic                     goto_active;
  logic                     started_positive;

  // per-item working registers
  logic [OP_W-1:0]   op_r;
  logic [DATA_W-1:0] acc_r;
  logic [DATA_W-1:0] diff_r;
  logic              neg_r;
  logic [DIVR_W-1:0] divisor;
  logic [PROD_W-1:0] quo;        // dividend shifts out, quotient shifts in
  logic [DIVR_W-1:0] rem;
  logic [CNT_W-1:0]  cnt;
  motor_cmd_t        cmd_r;

  // output register
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_offset;
  logic signed [DATA_W-1:0] out_stored;
  logic [CMD_W-1:0]         out_cmd;
  logic                     out_busy;

  logic in_fire;
  logic out_free;

  assign in_ch.ready = (state == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;

  assign out_ch.valid         = out_valid;
  assign out_ch.offset        = out_offset;
  assign out_ch.stored_offset = out_stored;
  assign out_ch.motor_cmd     = out_cmd;
  assign out_ch.goto_busy     = out_busy;

  // ---- datapath ----
  logic [DATA_W-1:0] diff;
  logic [DATA_W-1:0] diff_mag;
  logic [PROD_W-1:0] mul_prod;
  logic [DIVR_W-1:0] divr_prod;
  logic [DIVR_W:0]   rem_sh;
  logic              rem_ge;
  logic [DIVR_W:0]   rem_sub;
  logic [SUM_W-1:0]  quo_ext;
  logic [SUM_W-1:0]  quo_signed;
  logic [SUM_W-1:0]  sum;
  logic              sum_ovf;
  logic [DATA_W-1:0] sum_sat;

  assign diff      = acc_r - last_sample;
  assign diff_mag  = diff_r[DATA_W-1] ? (~diff_r + DATA_W'(1)) : diff_r;
  assign mul_prod  = PROD_W'(diff_mag) * PROD_W'(PULSE_SCALE);
  assign divr_prod = DIVR_W'(pair_count) * DIVR_W'(ratio_x10);

  // restoring divider step
  assign rem_sh  = {rem, quo[PROD_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};

  // signed quotient added to offset, saturated to 32 bits
  assign quo_ext    = {2'b00, quo};
  assign quo_signed = neg_r ? (~quo_ext + SUM_W'(1)) : quo_ext;
  assign sum        = {{(SUM_W-DATA_W){live_offset[DATA_W-1]}}, live_offset} + quo_signed;
  assign sum_ovf    = !((&sum[SUM_W-1:DATA_W-1]) || !(|sum[SUM_W-1:DATA_W-1]));
  assign sum_sat    = sum[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};

  // threshold window
  logic [THR_W-1:0]       thr_eff;
  logic signed [DATA_W:0] thr_pos;
  logic signed [DATA_W:0] thr_neg;
  logic signed [DATA_W:0] live_ext;
  logic                   in_window;
  logic                   live_pos;
  logic                   above_win;
  logic                   below_win;

  always_comb begin
    if (zero_threshold < THRESH_MIN) begin
      thr_eff = THRESH_MIN;
    end else if (zero_threshold > THRESH_MAX) begin
      thr_eff = THRESH_MAX;
    end else begin
      thr_eff = zero_threshold;
    end
  end

  assign thr_pos   = $signed({{(DATA_W+1-THR_W){1'b0}}, thr_eff});
  assign thr_neg   = -thr_pos;
  assign live_ext  = {live_offset[DATA_W-1], live_offset};
  assign above_win = live_ext > thr_pos;
  assign below_win = live_ext < thr_neg;
  assign in_window = !above_win && !below_win;
  assign live_pos  = !live_offset[DATA_W-1] && (|live_offset);

  // ---- configuration writes ----
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_count     <= PAIR_COUNT_RST;
      ratio_x10      <= RATIO_X10_RST;
      zero_threshold <= THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_PAIR_COUNT:     pair_count     <= cfg_data[PP_W-1:0];
        CFG_RATIO_X10:      ratio_x10      <= cfg_data[RATIO_W-1:0];
        CFG_ZERO_THRESHOLD: zero_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- sequencer and tracker state ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      live_offset      <= '0;
      last_sample      <= '0;
      saved_offset     <= '0;
      goto_active      <= 1'b0;
      started_positive <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      // in S_OUT a taken result is replaced by the new one below
      if (out_valid && out_ch.ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          state <= (op_r == OP_UPDATE) ? S_MUL : S_FIN;
        end
        S_MUL: begin
          if (|diff_r) begin
            last_sample <= acc_r;
          end
          // zero delta or zero gearing leaves the offset alone
          if ((|diff_r) && (|pair_count) && (|ratio_x10)) begin
            state <= S_DIV;
          end else begin
            state <= S_FIN;
          end
        end
        S_DIV: begin
          if (cnt == CNT_W'(PROD_W - 1)) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          live_offset <= sum_ovf ? sum_sat : sum[DATA_W-1:0];
          state       <= S_FIN;
        end
        S_FIN: begin
          case (op_r)
            OP_UPDATE: begin
              if (goto_active && (in_window || (live_pos != started_positive))) begin
                goto_active <= 1'b0;
              end
            end
            OP_SET_ZERO: begin
              live_offset  <= '0;
              saved_offset <= '0;
            end
            OP_SAVE: saved_offset <= live_offset;
            OP_GOTO_ZERO: begin
              if (above_win) begin
                goto_active      <= 1'b1;
                started_positive <= 1'b1;
              end else if (below_win) begin
                goto_active      <= 1'b1;
                started_positive <= 1'b0;
              end
            end
            OP_CAL_ZERO: begin
              live_offset  <= '0;
              saved_offset <= '0;
              last_sample  <= acc_r;
            end
            OP_RESYNC: begin
              live_offset <= saved_offset;
              last_sample <= acc_r;
            end
            default: ;
          endcase
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---- working and output payload registers ----
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_ch.op;
      acc_r <= in_ch.accum;
    end
    if (state == S_PREP) begin
      diff_r <= diff;
    end
    if (state == S_MUL) begin
      neg_r   <= diff_r[DATA_W-1];
      quo     <= mul_prod;
      divisor <= divr_prod;
      rem     <= '0;
      cnt     <= '0;
    end
    if (state == S_DIV) begin
      rem <= rem_ge ? rem_sub[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
      quo <= {quo[PROD_W-2:0], rem_ge};
      cnt <= cnt + CNT_W'(1);
    end
    if (state == S_FIN) begin
      cmd_r <= CMD_NONE;
      case (op_r)
        OP_UPDATE: begin
          if (goto_active && (in_window || (live_pos != started_positive))) begin
            cmd_r <= CMD_STOP;
          end
        end
        OP_GOTO_ZERO: begin
          if (above_win) begin
            cmd_r <= CMD_RUN_REV;
          end else if (below_win) begin
            cmd_r <= CMD_RUN_FWD;
          end
        end
        default: ;
      endcase
    end
    if ((state == S_OUT) && out_free) begin
      out_offset <= live_offset;
      out_stored <= saved_offset;
      out_cmd    <= cmd_r;
      out_busy   <= goto_active;
    end
  end

  // ---- assertions ----
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < divisor))
    else $error("divider remainder not below divisor");

  a_stop_clears_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_cmd == CMD_STOP)) |-> !out_busy)
    else $error("stop issued while goto still busy");

  a_run_sets_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ((out_cmd == CMD_RUN_REV) || (out_cmd == CMD_RUN_FWD))) |-> out_busy)
    else $error("run issued without goto busy");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == S_PREP))
    else $error("accepted item did not start the sequencer");

endmodule

@@ bench/hall_angle_tracker_goto_zero_top_test.sv @@
`timescale 1ns / 100ps

module hall_angle_tracker_goto_zero_top_test;
  import hatgz_pkg::*;

  // Op codes the block must ignore: no state change, no motor command.
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

  localparam int N_PHASES         = 8;
  localparam int ITEMS_PER_PHASE  = 210;
  // Longest item is an update through the serial divider.
  localparam int SETTLE_CYCLES    = 60;

  // One result item, in port order.
  typedef struct packed {
    logic signed [DATA_W-1:0] offset;
    logic signed [DATA_W-1:0] stored_offset;
    motor_cmd_t               motor_cmd;
    logic                     goto_busy;
  } angle_result_t;

  // One stimulus row; typed rows carry a hand-written expectation.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] accum;
    logic              typed;
    angle_result_t     want;
  } stim_row_t;

  localparam angle_result_t NO_RESULT = '0;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  hatgz_in_if  in_ch ();
  hatgz_out_if out_ch ();

  hall_angle_tracker_goto_zero_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #5 clk = ~clk;

  // Hard stop, well past the slowest legal run: roughly 1700 items, each an update
  // through the divider with the longest input gap and the longest output stall.
  initial begin
    #15_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Predictor state: gearing registers and tracker state, mirrored from the
  // block's view after reset and after each register write.
  logic [PP_W-1:0]          gear_pp;
  logic [RATIO_W-1:0]       gear_ratio;
  logic [THR_W-1:0]         gear_thr;
  logic signed [DATA_W-1:0] trk_live;
  logic signed [DATA_W-1:0] trk_saved;
  logic [DATA_W-1:0]        trk_last;
  logic                     trk_goto;
  logic                     trk_pos;

  angle_result_t expected_angles[$];   // results still owed by the block, oldest first
  int            mismatch_count = 0;
  bit            calm = 1'b0;          // phase with no gaps and no stalls
  logic [DATA_W-1:0] hall_pos;         // simulated free-running pulse counter
  int            stall_left = 0;

  // Advance the tracker by one item and return what the block should report.
  function automatic angle_result_t track_angle(logic [OP_W-1:0] op, logic [DATA_W-1:0] acc);
    angle_result_t res;
    logic [DATA_W-1:0] diff;
    longint thr, live, scaled, sum;
    res = NO_RESULT;
    // threshold register is clamped into the legal window
    thr = longint'(gear_thr);
    if (thr < longint'(THRESH_MIN)) thr = longint'(THRESH_MIN);
    if (thr > longint'(THRESH_MAX)) thr = longint'(THRESH_MAX);
    case (op)
      OP_UPDATE: begin
        diff = acc - trk_last;   // wrapping pulse delta
        if (diff != '0) begin
          trk_last = acc;
          if (gear_pp != '0 && gear_ratio != '0) begin
            scaled = longint'(signed'(diff)) * longint'(PULSE_SCALE);
            // longint division truncates toward zero
            sum = longint'(trk_live) + scaled / (longint'(gear_pp) * longint'(gear_ratio));
            if (sum > longint'(S32_MAX)) sum = longint'(S32_MAX);
            else if (sum < longint'(S32_MIN)) sum = longint'(S32_MIN);
            trk_live = sum[DATA_W-1:0];
          end
        end
        live = longint'(trk_live);
        // goto ends inside the window or once the offset crossed zero
        if (trk_goto && (((live < 0) ? -live : live) <= thr || (live > 0) != trk_pos)) begin
          res.motor_cmd = CMD_STOP;
          trk_goto = 1'b0;
        end
      end
      OP_SET_ZERO: begin
        trk_live = '0;
        trk_saved = '0;
      end
      OP_SAVE: begin
        trk_saved = trk_live;
      end
      OP_GOTO_ZERO: begin
        live = longint'(trk_live);
        if (live > thr) begin
          res.motor_cmd = CMD_RUN_REV;
          trk_goto = 1'b1;
          trk_pos = 1'b1;
        end else if (live < -thr) begin
          res.motor_cmd = CMD_RUN_FWD;
          trk_goto = 1'b1;
          trk_pos = 1'b0;
        end
      end
      OP_CAL_ZERO: begin
        trk_live = '0;
        trk_saved = '0;
        trk_last = acc;
      end
      OP_RESYNC: begin
        trk_live = trk_saved;
        trk_last = acc;
      end
      default: begin
      end
    endcase
    res.offset = trk_live;
    res.stored_offset = trk_saved;
    res.goto_busy = trk_goto;
    return res;
  endfunction

  // Idle length for either side: mostly none or short, a few long.
  function automatic int pick_idle();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    mismatch_count++;
    $display("%0t mismatch on %s: got %0d want %0d", $time, what, got, want);
  endtask

  // Present one item after a random gap; predict at the accepting edge.
  // valid is left high on return so a back-to-back item needs no toggle.
  task automatic send_item(stim_row_t row);
    int gap;
    angle_result_t res;
    gap = pick_idle();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= row.op;
    in_ch.accum <= row.accum;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    res = track_angle(row.op, row.accum);
    expected_angles.push_back(row.typed ? row.want : res);
  endtask

  // Hold the input side off until every owed result is back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_angles.size() != 0) @(posedge clk);
  endtask

  // Write all three registers on consecutive edges; block must be idle.
  task automatic load_gearing(logic [PP_W-1:0] pp, logic [RATIO_W-1:0] ratio,
                              logic [THR_W-1:0] thr);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PAIR_COUNT;
    cfg_data  <= CFG_W'(pp);
    @(posedge clk);
    cfg_index <= CFG_RATIO_X10;
    cfg_data  <= CFG_W'(ratio);
    @(posedge clk);
    cfg_index <= CFG_ZERO_THRESHOLD;
    cfg_data  <= CFG_W'(thr);
    @(posedge clk);
    cfg_we <= 1'b0;
    gear_pp = pp;
    gear_ratio = ratio;
    gear_thr = thr;
  endtask

  // Directed rows, run with reset gearing (3 pole pairs, ratio 1.0, so one
  // pulse is 300 units; window 50). Typed rows are obvious by inspection.
  stim_row_t directed_rows [0:24] = '{
    // update with no pulse change right after reset
    '{OP_UPDATE,    32'h0000_0000, 1'b1, '{32'sd0, 32'sd0, CMD_NONE, 1'b0}},
    '{OP_UPDATE,    32'h0000_0001, 1'b0, NO_RESULT},
    '{OP_SAVE,      32'h5A5A_A5A5, 1'b0, NO_RESULT},
    '{OP_GOTO_ZERO, 32'hFFFF_FFFF, 1'b0, NO_RESULT},   // positive offset: run reverse
    '{OP_UPDATE,    32'h0000_0001, 1'b0, NO_RESULT},   // no delta, still outside window
    '{OP_UPDATE,    32'hFFFF_FFFF, 1'b0, NO_RESULT},   // crosses zero: stop
    '{OP_GOTO_ZERO, 32'h0000_0000, 1'b0, NO_RESULT},   // negative offset: run forward
    '{OP_GOTO_ZERO, 32'h0000_0000, 1'b0, NO_RESULT},   // restart while active
    '{OP_UPDATE,    32'h0000_0000, 1'b0, NO_RESULT},   // lands on zero: stop
    '{OP_GOTO_ZERO, 32'h1234_5678, 1'b0, NO_RESULT},   // already inside window
    '{OP_RESYNC,    32'h0000_0064, 1'b0, NO_RESULT},
    '{OP_SPARE_6,   32'hA5A5_5A5A, 1'b0, NO_RESULT},
    '{OP_SPARE_7,   32'h5A5A_A5A5, 1'b0, NO_RESULT},
    '{OP_SET_ZERO,  32'hFFFF_0000, 1'b1, '{32'sd0, 32'sd0, CMD_NONE, 1'b0}},
    '{OP_CAL_ZERO,  32'h0000_0000, 1'b1, '{32'sd0, 32'sd0, CMD_NONE, 1'b0}},
    // saturation at both ends
    '{OP_UPDATE,    32'h7FFF_FFFF, 1'b1, '{S32_MAX, 32'sd0, CMD_NONE, 1'b0}},
    '{OP_UPDATE,    32'h8000_0000, 1'b1, '{S32_MAX, 32'sd0, CMD_NONE, 1'b0}},
    '{OP_SAVE,      32'h0000_0000, 1'b1, '{S32_MAX, S32_MAX, CMD_NONE, 1'b0}},
    '{OP_CAL_ZERO,  32'h0000_0000, 1'b1, '{32'sd0, 32'sd0, CMD_NONE, 1'b0}},
    '{OP_UPDATE,    32'h8000_0000, 1'b1, '{S32_MIN, 32'sd0, CMD_NONE, 1'b0}},
    '{OP_UPDATE,    32'h7FFF_FFFF, 1'b1, '{S32_MIN, 32'sd0, CMD_NONE, 1'b0}},
    '{OP_GOTO_ZERO, 32'h0000_0000, 1'b1, '{S32_MIN, 32'sd0, CMD_RUN_FWD, 1'b1}},
    // resync keeps goto running; next update finds it inside the window
    '{OP_RESYNC,    32'h0000_0000, 1'b1, '{32'sd0, 32'sd0, CMD_NONE, 1'b1}},
    '{OP_UPDATE,    32'h0000_0000, 1'b1, '{32'sd0, 32'sd0, CMD_STOP, 1'b0}},
    '{OP_UPDATE,    32'hFFFF_FFFF, 1'b0, NO_RESULT}
  };

  // Result side: random stalls on ready, and every accepted item is checked
  // field by field against the oldest owed result.
  always @(posedge clk) begin
    angle_result_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (expected_angles.size() == 0) begin
          flag_mismatch("unexpected item, offset", longint'(out_ch.offset), 0);
        end else begin
          want = expected_angles.pop_front();
          if (out_ch.offset !== want.offset)
            flag_mismatch("offset", longint'(out_ch.offset), longint'(want.offset));
          if (out_ch.stored_offset !== want.stored_offset)
            flag_mismatch("stored_offset", longint'(out_ch.stored_offset),
                          longint'(want.stored_offset));
          if (out_ch.motor_cmd !== want.motor_cmd)
            flag_mismatch("motor_cmd", longint'(out_ch.motor_cmd), longint'(want.motor_cmd));
          if (out_ch.goto_busy !== want.goto_busy)
            flag_mismatch("goto_busy", longint'(out_ch.goto_busy), longint'(want.goto_busy));
        end
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = pick_idle();
      end
    end
  end

  // Main sequence: reset, directed rows, then random phases under different
  // gearing. Each phase boundary drains the block before touching registers.
  initial begin
    stim_row_t row;
    int pick, delta;
    longint mag, need;
    in_ch.valid = 1'b0;
    in_ch.op = '0;
    in_ch.accum = '0;
    gear_pp = PAIR_COUNT_RST;
    gear_ratio = RATIO_X10_RST;
    gear_thr = THRESHOLD_RST;
    trk_live = '0;
    trk_saved = '0;
    trk_last = '0;
    trk_goto = 1'b0;
    trk_pos = 1'b0;
    hall_pos = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) send_item(directed_rows[i]);

    for (int p = 0; p < N_PHASES; p++) begin
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clk);
      calm = (p % 3 == 1);
      case (p)
        0: load_gearing(8'd3, 16'd10, 11'd50);          // reset values
        1: load_gearing(8'd1, 16'd1, 11'd1);            // coarsest step, tightest window
        2: load_gearing(8'd255, 16'd65535, 11'd1800);   // finest step, widest window
        3: load_gearing(8'd0, 16'd10, 11'd50);          // no pole pairs: frozen offset
        4: load_gearing(8'd4, 16'd0, 11'd2047);         // no ratio; window clamps to max
        5: load_gearing(8'd7, 16'd25, 11'd0);           // window clamps to min
        default: load_gearing(PP_W'($urandom_range(1, 255)),
                              RATIO_W'($urandom_range(1, 65535)),
                              THR_W'($urandom_range(0, 2047)));
      endcase

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // now and then hold off until the block has answered everything
        if ($urandom_range(0, 99) == 0) drain_results();
        row = '0;
        row.accum = $urandom();   // noise for ops that ignore accum
        pick = $urandom_range(0, 99);
        if (pick < 64) begin
          row.op = OP_UPDATE;
          if (trk_goto && $urandom_range(0, 9) < 7) begin
            // drive the shaft back toward zero, sometimes overshooting
            mag = longint'(trk_live);
            if (mag < 0) mag = -mag;
            need = mag * longint'(gear_pp) * longint'(gear_ratio) / longint'(PULSE_SCALE);
            if (need > 200000) need = 200000;
            delta = $urandom_range(1, 1 + int'(need));
            hall_pos = trk_pos ? hall_pos - DATA_W'(delta) : hall_pos + DATA_W'(delta);
          end else begin
            delta = $urandom_range(0, 99);
            if (delta < 75) hall_pos = hall_pos + DATA_W'($urandom_range(0, 40) - 20);
            else if (delta < 95)
              hall_pos = hall_pos + DATA_W'($urandom_range(0, 200000) - 100000);
            else hall_pos = $urandom();
          end
          row.accum = hall_pos;
        end else if (pick < 76) begin
          row.op = OP_GOTO_ZERO;
        end else if (pick < 83) begin
          row.op = OP_SAVE;
        end else if (pick < 86) begin
          row.op = OP_SET_ZERO;
        end else if (pick < 96) begin
          row.op = (pick < 90) ? OP_CAL_ZERO : OP_RESYNC;
          if ($urandom_range(0, 3) == 0) hall_pos = $urandom();
          row.accum = hall_pos;
        end else begin
          row.op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
        end
        send_item(row);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/hatgz_pkg.sv
src/hatgz_in_if.sv
src/hatgz_out_if.sv
src/hall_angle_tracker_goto_zero_top.sv
bench/hall_angle_tracker_goto_zero_top_test.sv
